/* sv/assert_macros.svh */
// assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, skipped while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/hbd_pkg.sv */
`default_nettype none

package hbd_pkg;

    localparam int MAX_FRAME_BYTES = 1024;

    localparam int CFG_W      = 11;
    localparam int INDEX_W    = 10;
    localparam int SYNC_W     = 2;
    localparam int BITCNT_W   = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] FLAG_PATTERN  = 8'h7e;
    localparam logic [7:0] ABORT_PATTERN = 8'hfe;
    localparam logic [7:0] STUFF_MASK    = 8'hfc;
    localparam logic [7:0] STUFF_PATTERN = 8'h7c;

    localparam logic [CFG_W-1:0] MIN_LEN_RESET  = CFG_W'(17);
    localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(MAX_FRAME_BYTES);
    localparam logic [CFG_W-1:0] CAPACITY_MAX   = CFG_W'(MAX_FRAME_BYTES);

    localparam logic [SYNC_W-1:0] SYNC_LOCKED = 2'd2;
    localparam logic [SYNC_W-1:0] SYNC_FULL   = 2'd3;

    typedef enum logic {
        REG_MIN_LEN  = 1'b0,
        REG_CAPACITY = 1'b1
    } reg_sel_t;

endpackage

`default_nettype wire

/* sv/hdlc_bit_deframer.sv */
// HDLC receive deframer working on one line bit per transfer. It takes a bit
// every clock and returns exactly one result per bit, in the next cycle, from
// an output register; the input side stays ready while that register is
// empty or being taken, so the sustained rate is one bit per clock and only
// backpressure on the result side slows it. Results carry completed bytes with
// their buffer index, frame end with length, overflow, abort and sync status.
// Registers over the APB port: 0x0 min_frame_len, 0x4 frame_capacity.
`default_nettype none

module hdlc_bit_deframer
    import hbd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_rx_bit,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [7:0]            m_data_byte,
    output logic                       m_byte_valid,
    output logic      [INDEX_W-1:0]    m_byte_index,
    output logic                       m_frame_done,
    output logic      [CFG_W-1:0]      m_frame_length,
    output logic                       m_frame_overflow,
    output logic                       m_abort_seen,
    output logic                       m_in_sync
);

    logic [CFG_W-1:0]    min_len_reg;
    logic [CFG_W-1:0]    capacity_reg;

    logic [7:0]          window_reg,    window_next;
    logic [7:0]          shifter_reg,   shifter_next;
    logic [BITCNT_W-1:0] bit_cnt_reg,   bit_cnt_next;
    logic [SYNC_W-1:0]   sync_reg,      sync_next;
    logic [CFG_W-1:0]    byte_cnt_reg,  byte_cnt_next;

    logic                out_valid_reg;
    logic [7:0]          data_next;
    logic                byte_valid_next;
    logic [INDEX_W-1:0]  index_next;
    logic                done_next;
    logic [CFG_W-1:0]    length_next;
    logic                overflow_next;
    logic                abort_next;

    logic                cfg_wr;
    logic                in_xfer;
    logic [CFG_W-1:0]    cap_eff;
    logic [CFG_W-1:0]    byte_cnt_inc;
    reg_sel_t            reg_sel;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = reg_sel_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg  <= MIN_LEN_RESET;
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MIN_LEN:  min_len_reg  <= pwdata[CFG_W-1:0];
                REG_CAPACITY: capacity_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MIN_LEN:  prdata = APB_DATA_W'(min_len_reg);
            REG_CAPACITY: prdata = APB_DATA_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    // handshake
    assign s_ready = !out_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    assign cap_eff = (capacity_reg == '0 || capacity_reg > CAPACITY_MAX) ?
                     CAPACITY_MAX : capacity_reg;
    assign byte_cnt_inc = byte_cnt_reg + CFG_W'(1);

    // per-bit deframing
    always_comb begin
        window_next     = {s_rx_bit, window_reg[7:1]};
        shifter_next    = shifter_reg;
        bit_cnt_next    = bit_cnt_reg;
        sync_next       = sync_reg;
        byte_cnt_next   = byte_cnt_reg;
        data_next       = '0;
        byte_valid_next = 1'b0;
        index_next      = '0;
        done_next       = 1'b0;
        length_next     = '0;
        overflow_next   = 1'b0;
        abort_next      = 1'b0;

        if (window_next == FLAG_PATTERN) begin
            if (sync_reg != SYNC_FULL) begin
                sync_next = sync_reg + SYNC_W'(1);
            end
            if (sync_next == SYNC_FULL) begin
                if (byte_cnt_reg >= min_len_reg) begin
                    done_next   = 1'b1;
                    length_next = byte_cnt_reg;
                end
                byte_cnt_next = '0;
                bit_cnt_next  = '0;
            end
        end else if (window_next == ABORT_PATTERN) begin
            abort_next    = 1'b1;
            sync_next     = '0;
            byte_cnt_next = '0;
            bit_cnt_next  = '0;
        end else if ((window_next & STUFF_MASK) == STUFF_PATTERN) begin
            // stuffed zero, dropped
        end else if (sync_reg >= SYNC_LOCKED) begin
            shifter_next = {window_next[7], shifter_reg[7:1]};
            bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
            if (bit_cnt_next == '0) begin
                byte_valid_next = 1'b1;
                data_next       = shifter_next;
                index_next      = byte_cnt_reg[INDEX_W-1:0];
                byte_cnt_next   = byte_cnt_inc;
                if (byte_cnt_inc >= cap_eff) begin
                    overflow_next = 1'b1;
                    byte_cnt_next = '0;
                end
            end
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            shifter_reg   <= '0;
            bit_cnt_reg   <= '0;
            sync_reg      <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                window_reg   <= window_next;
                shifter_reg  <= shifter_next;
                bit_cnt_reg  <= bit_cnt_next;
                sync_reg     <= sync_next;
                byte_cnt_reg <= byte_cnt_next;
            end
            if (s_ready) begin
                out_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_byte      <= data_next;
            m_byte_valid     <= byte_valid_next;
            m_byte_index     <= index_next;
            m_frame_done     <= done_next;
            m_frame_length   <= length_next;
            m_frame_overflow <= overflow_next;
            m_abort_seen     <= abort_next;
            m_in_sync        <= (sync_next >= SYNC_LOCKED);
        end
    end

endmodule

`default_nettype wire

/* sv/hbd_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module hbd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_data_byte,
    input wire logic        m_byte_valid,
    input wire logic [9:0]  m_byte_index,
    input wire logic        m_frame_done,
    input wire logic [10:0] m_frame_length,
    input wire logic        m_frame_overflow,
    input wire logic        m_abort_seen,
    input wire logic        m_in_sync
);

    // a held result keeps its content
    `ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data_byte) && $stable(m_byte_index))

    // overflow only on the byte that fills the buffer
    `ASSERT_IMP(a_ovf_byte, aclk, aresetn, m_valid && m_frame_overflow, m_byte_valid && m_in_sync)

    // abort drops sync
    `ASSERT_IMP(a_abort_sync, aclk, aresetn, m_valid && m_abort_seen, !m_in_sync && !m_byte_valid && !m_frame_done)

    // frame end only while synchronized, and no byte with it
    `ASSERT_IMP(a_done_sync, aclk, aresetn, m_valid && m_frame_done, m_in_sync && !m_byte_valid)

    // idle fields read zero
    `ASSERT_IMP(a_zero_fields, aclk, aresetn, m_valid && !m_byte_valid, m_data_byte == 8'd0 && m_byte_index == 10'd0 && (m_frame_done || m_frame_length == 11'd0))

endmodule

bind hdlc_bit_deframer hbd_checker u_hbd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_data_byte      (m_data_byte),
    .m_byte_valid     (m_byte_valid),
    .m_byte_index     (m_byte_index),
    .m_frame_done     (m_frame_done),
    .m_frame_length   (m_frame_length),
    .m_frame_overflow (m_frame_overflow),
    .m_abort_seen     (m_abort_seen),
    .m_in_sync        (m_in_sync)
);

`default_nettype wire

/* tb/sv/hdlc_bit_deframer_tb.sv */
`timescale 1ns / 100ps

module hdlc_bit_deframer_tb;
    import hbd_pkg::*;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               byte_valid;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_done;
        logic [CFG_W-1:0]   frame_length;
        logic               frame_overflow;
        logic               abort_seen;
        logic               in_sync;
    } rx_result_t;

    typedef struct packed {
        logic rx;
        logic typed;
        logic abort;
        logic sync;
    } probe_row_t;

    localparam int PHASES     = 7;
    localparam int PHASE_BITS = 220;

    // rx, typed, abort, sync
    localparam probe_row_t PROBE_ROWS [24] = '{
        4'b0100, 4'b1100, 4'b1100, 4'b1100, 4'b1100, 4'b1100, 4'b1100, 4'b0100,
        4'b0100, 4'b1100, 4'b1100, 4'b1100, 4'b1100, 4'b1100, 4'b1100, 4'b0101,
        4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1000, 4'b1000,
        4'b1110,
        4'b0000
    };

    localparam int PHASE_MIN [PHASES] = '{17, 0, 1, 3, 20, 1024, 2};
    localparam int PHASE_CAP [PHASES] = '{1024, 2047, 1, 0, 8, 1024, 5};

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_rx_bit;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_data_byte;
    logic                  m_byte_valid;
    logic [INDEX_W-1:0]    m_byte_index;
    logic                  m_frame_done;
    logic [CFG_W-1:0]      m_frame_length;
    logic                  m_frame_overflow;
    logic                  m_abort_seen;
    logic                  m_in_sync;

    // predictor state and register copies
    logic [7:0]          line_window;
    logic [7:0]          byte_acc;
    logic [BITCNT_W-1:0] acc_bits;
    logic [SYNC_W-1:0]   flag_count;
    logic [CFG_W-1:0]    frame_bytes;
    logic [CFG_W-1:0]    min_len_cfg;
    logic [CFG_W-1:0]    capacity_cfg;

    rx_result_t pending_results [$];
    rx_result_t seen_result;
    rx_result_t want_result;
    rx_result_t probe_want;
    rx_result_t hold_want;
    logic       hold_typed;

    int mismatch_count;
    int result_no;
    int bits_sent;
    int ones_run;
    int phase_end;
    int n_bytes;
    int cap_eff;
    int kind;
    logic [7:0] rand_byte;
    logic gaps_on;
    logic stall_on;

    hdlc_bit_deframer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_bit         (s_rx_bit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_byte_valid     (m_byte_valid),
        .m_byte_index     (m_byte_index),
        .m_frame_done     (m_frame_done),
        .m_frame_length   (m_frame_length),
        .m_frame_overflow (m_frame_overflow),
        .m_abort_seen     (m_abort_seen),
        .m_in_sync        (m_in_sync)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic rx_result_t deframe_bit(input logic rx);
        rx_result_t r;
        logic [CFG_W-1:0] cap;
        r = '0;
        cap = (capacity_cfg == '0 || capacity_cfg > CAPACITY_MAX) ? CAPACITY_MAX : capacity_cfg;
        line_window = {rx, line_window[7:1]};
        if (line_window == FLAG_PATTERN) begin
            if (flag_count != SYNC_FULL)
                flag_count = flag_count + 1'b1;
            if (flag_count == SYNC_FULL) begin
                if (frame_bytes >= min_len_cfg) begin
                    r.frame_done   = 1'b1;
                    r.frame_length = frame_bytes;
                end
                frame_bytes = '0;
                acc_bits    = '0;
            end
        end else if (line_window == ABORT_PATTERN) begin
            r.abort_seen = 1'b1;
            flag_count   = '0;
            frame_bytes  = '0;
            acc_bits     = '0;
        end else if ((line_window & STUFF_MASK) == STUFF_PATTERN) begin
            // stuffed zero, dropped
        end else if (flag_count >= SYNC_LOCKED) begin
            byte_acc = {line_window[7], byte_acc[7:1]};
            acc_bits = acc_bits + 1'b1;
            if (acc_bits == '0) begin
                r.byte_valid = 1'b1;
                r.data_byte  = byte_acc;
                r.byte_index = frame_bytes[INDEX_W-1:0];
                frame_bytes  = frame_bytes + 1'b1;
                if (frame_bytes >= cap) begin
                    r.frame_overflow = 1'b1;
                    frame_bytes      = '0;
                    acc_bits         = '0;
                end
            end
        end
        r.in_sync = (flag_count >= SYNC_LOCKED);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned seen,
                               input int unsigned want);
        if (seen != want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, want 0x%0h",
                                      result_no, name, seen, want));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_result = {m_data_byte, m_byte_valid, m_byte_index, m_frame_done,
                               m_frame_length, m_frame_overflow, m_abort_seen, m_in_sync};
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no input pending", result_no));
                end else begin
                    want_result = pending_results.pop_front();
                    check_field("data_byte", seen_result.data_byte, want_result.data_byte);
                    check_field("byte_valid", seen_result.byte_valid, want_result.byte_valid);
                    check_field("byte_index", seen_result.byte_index, want_result.byte_index);
                    check_field("frame_done", seen_result.frame_done, want_result.frame_done);
                    check_field("frame_length", seen_result.frame_length,
                                want_result.frame_length);
                    check_field("frame_overflow", seen_result.frame_overflow,
                                want_result.frame_overflow);
                    check_field("abort_seen", seen_result.abort_seen, want_result.abort_seen);
                    check_field("in_sync", seen_result.in_sync, want_result.in_sync);
                end
                result_no++;
            end
            if (s_valid && s_ready) begin
                want_result = deframe_bit(s_rx_bit);
                if (hold_typed)
                    want_result = hold_want;
                pending_results.push_back(want_result);
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_bit(input logic b, input logic typed = 1'b0,
                            input rx_result_t typed_res = '0);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_rx_bit   <= b;
        hold_typed = typed;
        hold_want  = typed_res;
        do @(posedge aclk); while (!s_ready);
        bits_sent++;
        @(negedge aclk);
    endtask

    task automatic send_flag();
        for (int i = 0; i < 8; i++)
            send_bit(FLAG_PATTERN[i]);
        ones_run = 0;
    endtask

    task automatic send_byte(input logic [7:0] v, input logic stuffed);
        for (int i = 0; i < 8; i++) begin
            send_bit(v[i]);
            ones_run = v[i] ? ones_run + 1 : 0;
            if (stuffed && ones_run == 5) begin
                send_bit(1'b0);
                ones_run = 0;
            end
        end
    endtask

    task automatic next_byte_value();
        case ($urandom_range(0, 7))
            0:       rand_byte = 8'hff;
            1:       rand_byte = FLAG_PATTERN;
            2:       rand_byte = 8'h1f;
            3:       rand_byte = 8'hf8;
            default: rand_byte = 8'($urandom_range(0, 255));
        endcase
    endtask

    task automatic run_sequence();
        cap_eff = (capacity_cfg == '0 || capacity_cfg > CAPACITY_MAX) ?
                  int'(CAPACITY_MAX) : int'(capacity_cfg);
        n_bytes = $urandom_range(0, 6);
        case ($urandom_range(0, 7))
            0, 1:    if (min_len_cfg <= 24) n_bytes = int'(min_len_cfg) - 1 + $urandom_range(0, 2);
            2:       if (cap_eff <= 24) n_bytes = cap_eff - 1 + $urandom_range(0, 2);
            default: ;
        endcase
        if (n_bytes < 0)
            n_bytes = 0;
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
            repeat ($urandom_range(0, 2)) send_flag();
            send_flag();
            repeat (n_bytes) begin
                next_byte_value();
                send_byte(rand_byte, 1'b1);
            end
            send_flag();
        end else if (kind < 15) begin
            // frame broken by an abort
            send_flag();
            repeat ($urandom_range(0, 4)) begin
                next_byte_value();
                send_byte(rand_byte, 1'b1);
            end
            repeat ($urandom_range(7, 10)) send_bit(1'b1);
            ones_run = 0;
        end else if (kind < 17) begin
            send_flag();
            repeat ($urandom_range(1, 6)) begin
                next_byte_value();
                send_byte(rand_byte, 1'b0);
            end
            ones_run = 0;
        end else begin
            repeat ($urandom_range(1, 24)) send_bit(1'($urandom_range(0, 1)));
            ones_run = 0;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_sel_t sel, input logic [CFG_W-1:0] wdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(sel) << 2;
        pwdata  <= APB_DATA_W'(wdata);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_MIN_LEN:  min_len_cfg  = wdata;
            REG_CAPACITY: capacity_cfg = wdata;
            default: ;
        endcase
    endtask

    initial begin
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_rx_bit       = 1'b0;
        hold_typed     = 1'b0;
        hold_want      = '0;
        gaps_on        = 1'b0;
        stall_on       = 1'b0;
        mismatch_count = 0;
        result_no      = 0;
        bits_sent      = 0;
        ones_run       = 0;
        line_window    = '0;
        byte_acc       = '0;
        acc_bits       = '0;
        flag_count     = '0;
        frame_bytes    = '0;
        min_len_cfg    = MIN_LEN_RESET;
        capacity_cfg   = CAPACITY_RESET;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // two flags to lock, then seven ones to abort
        for (int i = 0; i < 24; i++) begin
            probe_want            = '0;
            probe_want.abort_seen = PROBE_ROWS[i].abort;
            probe_want.in_sync    = PROBE_ROWS[i].sync;
            send_bit(PROBE_ROWS[i].rx, PROBE_ROWS[i].typed, probe_want);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                cfg_write(REG_MIN_LEN, CFG_W'(PHASE_MIN[p]));
                cfg_write(REG_CAPACITY, CFG_W'(PHASE_CAP[p]));
            end
            phase_end = bits_sent + PHASE_BITS;
            while (bits_sent < phase_end) begin
                gaps_on  = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
                stall_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
                run_sequence();
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
